// ===== hw/rtl/bleadv_pkg.sv =====
// shared types and constants for the advertising report filter and name extractor
package bleadv_pkg;

  localparam int REPORT_BYTES = 32;
  localparam int ADDR_W       = $clog2(REPORT_BYTES);
  localparam int CNT_W        = ADDR_W + 1;
  localparam int MAX_NAME_LEN = 29;

  localparam logic [7:0] AD_TYPE_FLAGS      = 8'h01;
  localparam logic [7:0] AD_TYPE_NAME_SHORT = 8'h08;
  localparam logic [7:0] AD_TYPE_NAME_FULL  = 8'h09;
  localparam logic [7:0] NAME_LEN_LIMIT     = 8'(MAX_NAME_LEN + 1);

  typedef enum logic [1:0] {
    DM_ALL     = 2'd0,
    DM_LIMITED = 2'd1,
    DM_GENERAL = 2'd2,
    DM_REJECT  = 2'd3
  } disc_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_LEN,
    ST_RD_TYPE,
    ST_CHK_TYPE,
    ST_RD_FV,
    ST_FINISH,
    ST_EMIT
  } walk_state_t;

  typedef struct packed {
    logic [7:0] ad_byte;
    logic       end_of_report;
  } item_t;

  typedef struct packed {
    logic       accepted;
    logic       flags_found;
    logic [7:0] flags_value;
    logic       name_found;
    logic [7:0] name_byte;
    logic [4:0] name_index;
    logic       last_result;
  } result_t;

  typedef struct packed {
    logic             go;
    logic [CNT_W-1:0] size;
  } walk_cmd_t;

endpackage

// ===== hw/rtl/bleadv_store.sv =====
// report byte memory, one write port and one registered read port
module bleadv_store
  import bleadv_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [REPORT_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/bleadv_walker.sv =====
// structure walk over the stored report and name result sequencer
module bleadv_walker
  import bleadv_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  walk_cmd_t         cmd,
  input  disc_mode_t        mode,
  input  logic [7:0]        rd_data,
  output logic [ADDR_W-1:0] rd_addr,
  output logic              busy,
  output logic              result_valid,
  output result_t           result
);

  walk_state_t state, state_next;

  logic [CNT_W-1:0]  size;
  logic [CNT_W-1:0]  off;
  logic [7:0]        len;
  logic              ff;
  logic [7:0]        fv;
  logic              name_done;
  logic              nf;
  logic [ADDR_W-1:0] name_start;
  logic [ADDR_W-1:0] nlen;
  logic [ADDR_W-1:0] idx;
  logic              acc;
  logic              out_pend;
  logic              out_mem;
  logic [ADDR_W-1:0] out_idx;
  logic              out_last;

  logic [8:0]        struct_end;
  logic              len_bad;
  logic              is_flags;
  logic              is_name;
  logic              fv_inside;
  logic              both_done;
  logic              name_stream;
  logic              emit_last;
  logic              acc_next;

  always_comb begin
    struct_end  = 9'(off) + 9'd1 + 9'(rd_data);
    len_bad     = (rd_data == 8'd0) || (struct_end > 9'(size));
    is_flags    = !ff && (rd_data == AD_TYPE_FLAGS);
    is_name     = !name_done
                  && ((rd_data == AD_TYPE_NAME_SHORT) || (rd_data == AD_TYPE_NAME_FULL));
    fv_inside   = (9'(off) + 9'd2) < 9'(size);
    both_done   = (ff || is_flags) && (name_done || is_name);
    name_stream = nf && (nlen != '0);
    emit_last   = (CNT_W'(idx) + CNT_W'(1)) == CNT_W'(nlen);
  end

  always_comb begin
    unique case (mode)
      DM_ALL:     acc_next = 1'b1;
      DM_LIMITED: acc_next = ff & fv[0];
      DM_GENERAL: acc_next = ff & (fv[0] | fv[1]);
      DM_REJECT:  acc_next = 1'b0;
      default:    acc_next = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.go) begin
          state_next = ST_RD_LEN;
        end
      end
      ST_RD_LEN: begin
        state_next = (off >= size) ? ST_FINISH : ST_RD_TYPE;
      end
      ST_RD_TYPE: begin
        state_next = len_bad ? ST_FINISH : ST_CHK_TYPE;
      end
      ST_CHK_TYPE: begin
        if (is_flags && fv_inside) begin
          state_next = ST_RD_FV;
        end else begin
          state_next = both_done ? ST_FINISH : ST_RD_LEN;
        end
      end
      ST_RD_FV: begin
        state_next = name_done ? ST_FINISH : ST_RD_LEN;
      end
      ST_FINISH: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!name_stream || emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rd_addr = off[ADDR_W-1:0];
    busy    = (state != ST_IDLE);
    unique case (state)
      ST_RD_TYPE:  rd_addr = ADDR_W'(off + CNT_W'(1));
      ST_CHK_TYPE: rd_addr = ADDR_W'(off + CNT_W'(2));
      ST_EMIT:     rd_addr = name_start + idx;
      default:     rd_addr = off[ADDR_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      out_pend <= 1'b0;
    end else begin
      state    <= state_next;
      out_pend <= (state == ST_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (cmd.go) begin
          size      <= cmd.size;
          off       <= '0;
          ff        <= 1'b0;
          fv        <= 8'd0;
          name_done <= 1'b0;
          nf        <= 1'b0;
        end
      end
      ST_RD_TYPE: begin
        len <= rd_data;
      end
      ST_CHK_TYPE: begin
        off <= CNT_W'(9'(off) + 9'd1 + 9'(len));
        if (is_flags) begin
          ff <= 1'b1;
        end
        if (is_name) begin
          name_done  <= 1'b1;
          nf         <= (len <= NAME_LEN_LIMIT);
          name_start <= ADDR_W'(off + CNT_W'(2));
          nlen       <= ADDR_W'(len - 8'd1);
        end
      end
      ST_RD_FV: begin
        fv <= rd_data;
      end
      ST_FINISH: begin
        acc <= acc_next;
        idx <= '0;
      end
      ST_EMIT: begin
        out_mem  <= name_stream;
        out_idx  <= name_stream ? idx : '0;
        out_last <= !name_stream || emit_last;
        idx      <= idx + ADDR_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result_valid       = out_pend;
    result.accepted    = acc;
    result.flags_found = ff;
    result.flags_value = fv;
    result.name_found  = nf;
    result.name_byte   = out_mem ? rd_data : 8'd0;
    result.name_index  = out_idx;
    result.last_result = out_last;
  end

endmodule

// ===== hw/rtl/ble_adv_report_filter_name_extract_core.sv =====
// advertising report filter and name extractor top level
// Takes one advertising-data byte per transaction (start while busy is low) and stores up to
// 32 bytes of a report; bytes beyond that are dropped. After a byte without the end mark busy
// stays low. After the end mark busy rises while the stored structures are walked through the
// single read port of the report memory, reading the length and type of each structure and the
// value of a flags structure; the walk is then closed, and one result is sent per name
// character, or one when no name character is sent; busy falls as the final result appears.
// Results come one per cycle on result with result_valid high for one cycle each, the final
// one marked by last_result; the receiver cannot stall them. The user must write discovery_mode
// through cfg_valid and cfg_data only while no report is in progress; this is not enforced.
module ble_adv_report_filter_name_extract_core
  import bleadv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  item_t      item,
  output logic       result_valid,
  output result_t    result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data
);

  logic              accept;
  logic              room;
  logic [CNT_W-1:0]  byte_count;
  logic [CNT_W-1:0]  size;
  disc_mode_t        mode;
  walk_cmd_t         cmd;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;

  assign accept    = start && !busy;
  assign room      = (byte_count < CNT_W'(REPORT_BYTES));
  assign cfg_ready = 1'b1;
  assign size      = room ? byte_count + CNT_W'(1) : byte_count;
  assign cmd.go    = accept && item.end_of_report;
  assign cmd.size  = size;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      mode       <= DM_ALL;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode <= disc_mode_t'(cfg_data);
      end
      if (accept) begin
        if (item.end_of_report) begin
          byte_count <= '0;
        end else if (room) begin
          byte_count <= byte_count + CNT_W'(1);
        end
      end
    end
  end

  bleadv_store u_store (
    .clk     (clk),
    .wr_en   (accept && room),
    .wr_addr (byte_count[ADDR_W-1:0]),
    .wr_data (item.ad_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bleadv_walker u_walker (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .mode         (mode),
    .rd_data      (rd_data),
    .rd_addr      (rd_addr),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
